// ----- design/tdl_pkg.sv -----
// shared constants and types for the tree distance engine
package tdl_pkg;

  localparam int NODE_W          = 10;
  localparam int LEN_W           = 11;
  localparam int DEPTH_W         = 11;
  localparam int MAX_NODES_DEF   = 1024;
  localparam int LIFT_LEVELS_DEF = 10;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_DEP,
    ST_LD_DW,
    ST_LD_RD,
    ST_LD_WR,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_ORD,
    ST_LIFT_CHK,
    ST_LIFT_WR,
    ST_JMP_EQ,
    ST_JMP_RU,
    ST_JMP_RV,
    ST_JMP_CMP,
    ST_LCA_RD,
    ST_LCA_WR,
    ST_LEN_RD,
    ST_LEN_WR,
    ST_DONE
  } tdl_state_e;

endpackage

// ----- design/tree_distance_lca_engine.sv -----
// top level of the binary lifting tree distance engine
//
// usage
// - input channel: in_valid_i / in_stall_o carries one word of action, node_a, node_b
// - action load stores node_a under parent node_b; parents go in before their children
// - action query returns one word on the output channel: the lowest common
//   ancestor of node_a and node_b and the edge count of the path between them
// - a load fills every lift level of the new node; a load of node zero is ignored
// - a query is paced by the single read port of the ancestor memory: one read per
//   lifted bit of the depth gap and two reads per level of the joint upward search
// - one word is worked on at a time; in_stall_o is high while it is busy
// - the result sits in an output register, so a new word is taken while the
//   receiver stalls; a finished query waits only if the register is still full
// - reset empties the output register and returns the sequencer to idle;
//   memory contents are not cleared, node zero is served by fixed values
module tree_distance_lca_engine
  import tdl_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [NODE_W-1:0]  node_a_i,
  input  logic [NODE_W-1:0]  node_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [NODE_W-1:0]  common_ancestor_o,
  output logic [LEN_W-1:0]   path_length_o
);

  localparam int NW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int LW    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int DW    = (LIFT_LEVELS > DEPTH_W) ? LIFT_LEVELS : DEPTH_W;
  localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);

  // out of range node numbers fold onto the sentinel
  function automatic logic [NW-1:0] to_node(input logic [NODE_W-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return (w < 32'(MAX_NODES)) ? w[NW-1:0] : '0;
  endfunction

  tdl_state_e state_q, state_d;

  logic [NW-1:0]      a_q, b_q, u_q, v_q, au_q, lca_q;
  logic [LW-1:0]      lvl_q;
  logic [DW-1:0]      diff_q;
  logic [DEPTH_W-1:0] da_q, db_q;
  logic [LEN_W-1:0]   len_q;

  // memory ports
  logic               dep_we, anc_we;
  logic [NW-1:0]      dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0] dep_wdata, dep_q, dep_rd;
  logic [NW+LW-1:0]   anc_waddr, anc_raddr;
  logic [NW-1:0]      anc_wdata, anc_q, anc_rd;
  logic               dep_rz_q, anc_rz_q;

  logic               in_acc;
  logic               out_free;
  logic signed [DEPTH_W:0] gap;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  // node zero is never written: depth -1 and an all-zero ancestor row
  assign dep_rd = dep_rz_q ? '1 : dep_q;
  assign anc_rd = anc_rz_q ? '0 : anc_q;

  // gap between the two query depths, read as they arrive
  assign gap = $signed({da_q[DEPTH_W-1], da_q}) - $signed({dep_rd[DEPTH_W-1], dep_rd});

  tdl_ram #(.WIDTH(DEPTH_W), .ADDR_W(NW)) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .raddr_i (dep_raddr),
    .rdata_o (dep_q)
  );

  tdl_ram #(.WIDTH(NW), .ADDR_W(NW + LW)) u_anc_ram (
    .clk_i   (clk_i),
    .we_i    (anc_we),
    .waddr_i (anc_waddr),
    .wdata_i (anc_wdata),
    .raddr_i (anc_raddr),
    .rdata_o (anc_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == ACT_QUERY) begin
            state_d = ST_Q_DA;
          end else if (to_node(node_a_i) != '0) begin
            state_d = ST_LD_DEP;
          end
        end
      end
      ST_LD_DEP:   state_d = ST_LD_DW;
      ST_LD_DW:    state_d = (LIFT_LEVELS == 1) ? ST_IDLE : ST_LD_RD;
      ST_LD_RD:    state_d = ST_LD_WR;
      ST_LD_WR:    state_d = (lvl_q == LVL_TOP) ? ST_IDLE : ST_LD_RD;
      ST_Q_DA:     state_d = ST_Q_DB;
      ST_Q_DB:     state_d = ST_Q_ORD;
      ST_Q_ORD:    state_d = ST_LIFT_CHK;
      ST_LIFT_CHK: begin
        if (diff_q[lvl_q]) begin
          state_d = ST_LIFT_WR;
        end else if (lvl_q == '0) begin
          state_d = ST_JMP_EQ;
        end
      end
      ST_LIFT_WR:  state_d = (lvl_q == '0) ? ST_JMP_EQ : ST_LIFT_CHK;
      ST_JMP_EQ:   state_d = (u_q == v_q) ? ST_LEN_RD : ST_JMP_RU;
      ST_JMP_RU:   state_d = ST_JMP_RV;
      ST_JMP_RV:   state_d = ST_JMP_CMP;
      ST_JMP_CMP:  state_d = (lvl_q == '0) ? ST_LCA_RD : ST_JMP_RU;
      ST_LCA_RD:   state_d = ST_LCA_WR;
      ST_LCA_WR:   state_d = ST_LEN_RD;
      ST_LEN_RD:   state_d = ST_LEN_WR;
      ST_LEN_WR:   state_d = ST_DONE;
      ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    dep_we    = 1'b0;
    dep_waddr = a_q;
    dep_wdata = dep_rd + DEPTH_W'(1);
    dep_raddr = a_q;
    anc_we    = 1'b0;
    anc_waddr = {a_q, lvl_q};
    anc_wdata = anc_rd;
    anc_raddr = {u_q, lvl_q};
    case (state_q)
      ST_LD_DEP: begin
        // parent depth read, first ancestor is the parent itself
        dep_raddr = b_q;
        anc_we    = 1'b1;
        anc_waddr = {a_q, LW'(0)};
        anc_wdata = b_q;
      end
      ST_LD_DW:   dep_we = 1'b1;
      ST_LD_RD:   anc_raddr = {u_q, lvl_q - LW'(1)};
      ST_LD_WR:   anc_we = 1'b1;
      ST_Q_DA:    dep_raddr = a_q;
      ST_Q_DB:    dep_raddr = b_q;
      ST_JMP_RV:  anc_raddr = {v_q, lvl_q};
      ST_LCA_RD:  anc_raddr = {u_q, LW'(0)};
      ST_LEN_RD:  dep_raddr = lca_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dep_rz_q <= (dep_raddr == '0);
    anc_rz_q <= (anc_raddr[NW+LW-1:LW] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        a_q <= to_node(node_a_i);
        b_q <= to_node(node_b_i);
      end
      ST_LD_DW: begin
        u_q   <= b_q;
        lvl_q <= LW'(1);
      end
      ST_LD_WR: begin
        u_q   <= anc_rd;
        lvl_q <= lvl_q + LW'(1);
      end
      ST_Q_DB:  da_q <= dep_rd;
      ST_Q_ORD: begin
        // deeper node goes to u
        lvl_q <= LVL_TOP;
        if (gap < 0) begin
          u_q    <= b_q;
          v_q    <= a_q;
          diff_q <= DW'(DEPTH_W'(-gap));
        end else begin
          u_q    <= a_q;
          v_q    <= b_q;
          diff_q <= DW'(DEPTH_W'(gap));
        end
        db_q <= dep_rd;
      end
      ST_LIFT_CHK: begin
        if (!diff_q[lvl_q] && lvl_q != '0) begin
          lvl_q <= lvl_q - LW'(1);
        end
      end
      ST_LIFT_WR: begin
        u_q <= anc_rd;
        if (lvl_q != '0) begin
          lvl_q <= lvl_q - LW'(1);
        end
      end
      ST_JMP_EQ: begin
        lca_q <= u_q;
        lvl_q <= LVL_TOP;
      end
      ST_JMP_RV:  au_q <= anc_rd;
      ST_JMP_CMP: begin
        if (au_q != anc_rd) begin
          u_q <= au_q;
          v_q <= anc_rd;
        end
        if (lvl_q != '0) begin
          lvl_q <= lvl_q - LW'(1);
        end
      end
      ST_LCA_WR: lca_q <= anc_rd;
      ST_LEN_WR: len_q <= LEN_W'(da_q + db_q - {dep_rd[DEPTH_W-2:0], 1'b0});
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      common_ancestor_o <= NODE_W'(32'(lca_q));
      path_length_o     <= len_q;
    end
  end

endmodule

// ----- design/tdl_ram.sv -----
// generic single write port ram with one registered read port
module tdl_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
